/* src/mchw_pkg.sv */
// Shared constants and types of the multi-channel hang watchdog.
`default_nettype none

package mchw_pkg;

  localparam int CHANNELS  = 8;
  localparam int TIME_BITS = 32;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    CMD_ATTACH   = 3'd0,
    CMD_DETACH   = 3'd1,
    CMD_ACTIVITY = 3'd2,
    CMD_WAIT     = 3'd3,
    CMD_TICK     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    EV_HANG_START = 2'd0,
    EV_HANG_END   = 2'd1,
    EV_PERMA      = 2'd2
  } ev_kind_e;

  typedef struct packed {
    logic                tick_start;
    logic                apply;
    logic                commit;
    logic                flush;
    logic [CH_IDX_W-1:0] idx;
  } ctl_t;

  typedef struct packed {
    logic stall;
    logic hold_valid;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* src/mchw_ctrl.sv */
// Controller of the watchdog: command acceptance, channel scan sequencing and flush.
`default_nettype none

module mchw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [2:0]    in_cmd_i,
  input  wire mchw_pkg::sts_t sts_i,
  output mchw_pkg::ctl_t     ctl_o
);
  import mchw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CH_IDX_W-1:0] idx_q, idx_d;
  logic                accept;
  logic                is_tick;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_tick    = (in_cmd_i == CMD_TICK);

  always_comb begin
    state_d          = state_q;
    idx_d            = idx_q;
    ctl_o.tick_start = 1'b0;
    ctl_o.apply      = 1'b0;
    ctl_o.commit     = 1'b0;
    ctl_o.flush      = 1'b0;
    ctl_o.idx        = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_tick) begin
            ctl_o.tick_start = 1'b1;
            idx_d            = '0;
            state_d          = ST_SCAN;
          end else begin
            ctl_o.apply = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (!sts_i.stall) begin
          ctl_o.commit = 1'b1;
          if (idx_q == CH_IDX_W'(CHANNELS - 1)) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d = idx_q + CH_IDX_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!sts_i.hold_valid) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          ctl_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

/* src/mchw_datapath.sv */
// Datapath of the watchdog: time counter, channel table, event check and output words.
`default_nettype none

module mchw_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mchw_pkg::ctl_t ctl_i,
  output mchw_pkg::sts_t      sts_o,
  input  wire logic [2:0]     cmd_i,
  input  wire logic [2:0]     chan_i,
  input  wire logic [31:0]    hlim_i,
  input  wire logic [31:0]    plim_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [1:0]          out_kind_o,
  output logic [2:0]          out_chan_o,
  output logic [31:0]         out_dur_o,
  output logic                out_last_o
);
  import mchw_pkg::*;

  logic [TIME_BITS-1:0] time_q;
  logic                 act_q   [CHANNELS];
  logic                 wait_q  [CHANNELS];
  logic                 hang_q  [CHANNELS];
  logic [TIME_BITS-1:0] last_q  [CHANNELS];
  logic [TIME_BITS-1:0] begin_q [CHANNELS];
  logic [TIME_BITS-1:0] hlim_q  [CHANNELS];
  logic [TIME_BITS-1:0] plim_q  [CHANNELS];

  logic                 hold_valid_q;
  logic [1:0]           hold_kind_q;
  logic [2:0]           hold_chan_q;
  logic [31:0]          hold_dur_q;

  logic                 out_valid_q;
  logic [1:0]           out_kind_q;
  logic [2:0]           out_chan_q;
  logic [31:0]          out_dur_q;
  logic                 out_last_q;

  logic [CH_IDX_W-1:0]  cidx;
  logic                 ch_ok;
  logic [TIME_BITS-1:0] hlim_conv, plim_conv;

  logic [TIME_BITS-1:0] elapsed, dur_end;
  logic                 ev_perma, ev_start, ev_end, ev_any;
  logic [1:0]           ev_kind;
  logic [31:0]          ev_dur;
  logic                 out_free, load_mid, load_fin;

  assign cidx      = CH_IDX_W'(chan_i);
  assign ch_ok     = (int'(chan_i) < CHANNELS);
  assign hlim_conv = (hlim_i == '1) ? '1 : TIME_BITS'(hlim_i);
  assign plim_conv = (plim_i == '1) ? '1 : TIME_BITS'(plim_i);

  always_comb begin
    elapsed  = time_q - last_q[ctl_i.idx];
    dur_end  = time_q - begin_q[ctl_i.idx];
    ev_perma = 1'b0;
    ev_start = 1'b0;
    ev_end   = 1'b0;
    if (act_q[ctl_i.idx] && !wait_q[ctl_i.idx]) begin
      if ((plim_q[ctl_i.idx] != '1) && (elapsed >= plim_q[ctl_i.idx])) begin
        ev_perma = 1'b1;
      end else if (!hang_q[ctl_i.idx]) begin
        ev_start = (hlim_q[ctl_i.idx] != '1) && (elapsed >= hlim_q[ctl_i.idx]);
      end else begin
        ev_end = (last_q[ctl_i.idx] != begin_q[ctl_i.idx]);
      end
    end
    ev_any = ev_perma || ev_start || ev_end;
    priority if (ev_perma) begin
      ev_kind = EV_PERMA;
      ev_dur  = 32'(plim_q[ctl_i.idx]);
    end else if (ev_end) begin
      ev_kind = EV_HANG_END;
      ev_dur  = 32'(dur_end);
    end else begin
      ev_kind = EV_HANG_START;
      ev_dur  = '0;
    end
  end

  assign out_free         = !out_valid_q || out_ready_i;
  assign sts_o.out_free   = out_free;
  assign sts_o.hold_valid = hold_valid_q;
  assign sts_o.stall      = ev_any && hold_valid_q && !out_free;
  assign load_mid         = ctl_i.commit && ev_any && hold_valid_q;
  assign load_fin         = ctl_i.flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q       <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        act_q[i] <= 1'b0;
      end
    end else begin
      if (ctl_i.tick_start) begin
        time_q <= time_q + TIME_BITS'(1);
      end
      if (ctl_i.apply && ch_ok) begin
        if (cmd_i == CMD_ATTACH) begin
          act_q[cidx] <= 1'b1;
        end else if (cmd_i == CMD_DETACH) begin
          act_q[cidx] <= 1'b0;
        end
      end
      if (ctl_i.commit && ev_any) begin
        hold_valid_q <= 1'b1;
      end else if (load_fin) begin
        hold_valid_q <= 1'b0;
      end
      if (load_mid || load_fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.apply && ch_ok) begin
      case (cmd_i)
        CMD_ATTACH: begin
          wait_q[cidx]  <= 1'b1;
          hang_q[cidx]  <= 1'b0;
          last_q[cidx]  <= time_q;
          begin_q[cidx] <= time_q;
          hlim_q[cidx]  <= hlim_conv;
          plim_q[cidx]  <= plim_conv;
        end
        CMD_ACTIVITY: begin
          if (act_q[cidx]) begin
            last_q[cidx] <= time_q;
            wait_q[cidx] <= 1'b0;
          end
        end
        CMD_WAIT: begin
          if (act_q[cidx] && !wait_q[cidx]) begin
            last_q[cidx] <= time_q;
            wait_q[cidx] <= 1'b1;
          end
        end
        default: ;
      endcase
    end else if (ctl_i.commit) begin
      if (ev_perma) begin
        wait_q[ctl_i.idx] <= 1'b1;
        hang_q[ctl_i.idx] <= 1'b0;
      end else if (ev_start) begin
        begin_q[ctl_i.idx] <= last_q[ctl_i.idx];
        hang_q[ctl_i.idx]  <= 1'b1;
      end else if (ev_end) begin
        hang_q[ctl_i.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit && ev_any) begin
      hold_kind_q <= ev_kind;
      hold_chan_q <= 3'(ctl_i.idx);
      hold_dur_q  <= ev_dur;
    end
    if (load_mid || load_fin) begin
      out_kind_q <= hold_kind_q;
      out_chan_q <= hold_chan_q;
      out_dur_q  <= hold_dur_q;
      out_last_q <= load_fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_chan_o  = out_chan_q;
  assign out_dur_o   = out_dur_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

/* src/multi_channel_hang_watchdog.sv */
// Top level of the multi-channel hang watchdog.
`default_nettype none

// Each input word is one command: attach, detach, activity, wait or tick.
// Attach, detach, activity and wait produce no output.
// A tick advances the shared time counter and then scans the channel table
// one entry per cycle unless the output side stalls, so it keeps the input
// busy through the accept, one scan step per channel and a flush step, and
// while the output side stalls. Each scanned channel yields at most one
// event word; events leave in ascending channel order and the final event
// of a tick carries tlast. A tick with no event yields no word.
module multi_channel_hang_watchdog (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // channel[2:0], hang_limit_in[34:3],
                                           // perma_limit_in[66:35], zero[71:67]
  input  wire logic [2:0]  s_axis_tuser,  // command[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // event_channel[2:0], hang_duration[34:3],
                                           // zero[39:35]
  output logic [1:0]       m_axis_tuser,  // event_kind[1:0]
  output logic             m_axis_tlast   // last_event
);
  import mchw_pkg::*;

  ctl_t        ctl;
  sts_t        sts;
  logic [2:0]  out_chan;
  logic [31:0] out_dur;

  mchw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  mchw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .cmd_i       (s_axis_tuser),
    .chan_i      (s_axis_tdata[2:0]),
    .hlim_i      (s_axis_tdata[34:3]),
    .plim_i      (s_axis_tdata[66:35]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_chan_o  (out_chan),
    .out_dur_o   (out_dur),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_dur, out_chan};

endmodule

`default_nettype wire

/* src/mchw_checker.sv */
// Port-level checker of the watchdog and its bind to the top level.
`default_nettype none

module mchw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [71:0] s_axis_tdata,
  input wire logic [2:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import mchw_pkg::*;

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_HANG_START) |-> (m_axis_tdata[34:3] == 32'd0))
    else $error("hang start word with nonzero duration");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == CMD_TICK) |=> !s_axis_tready)
    else $error("input ready right after a tick");

  a_cmd_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser != CMD_TICK) |=> s_axis_tready)
    else $error("input not ready after a single-cycle command");

endmodule

bind multi_channel_hang_watchdog mchw_checker u_mchw_checker (.*);

`default_nettype wire
